@@ sv/pfla_pkg.sv @@
// Shared types, widths and register codes of the pool free-list allocator.
package pfla_pkg;

  // Slots per block are fixed by the element index encoding (block * 64 + slot).
  localparam int MAX_BLOCK_SLOTS = 64;
  localparam int MAX_BLOCKS_DEF  = 16;
  localparam int MAX_ELEM_BYTES  = 4096;

  localparam int SLOT_W  = 6;
  localparam int BLOCK_W = 4;
  localparam int ELEM_W  = SLOT_W + BLOCK_W;
  localparam int EPB_W   = 7;
  localparam int BYTES_W = 13;
  localparam int OFF_W   = 18;
  localparam int CFG_W   = 13;

  typedef enum logic {
    CFG_ELEMENTS_PER_BLOCK = 1'b0,
    CFG_ELEMENT_BYTES      = 1'b1
  } pfla_cfg_e;

  typedef enum logic {
    OP_ALLOC = 1'b0,
    OP_FREE  = 1'b1
  } pfla_op_e;

  typedef enum logic {
    ST_DONE         = 1'b0,
    ST_OUT_OF_SPACE = 1'b1
  } pfla_status_e;

  // One free-list link: valid bit plus element index.
  typedef struct packed {
    logic              valid;
    logic [ELEM_W-1:0] idx;
  } pfla_link_t;

  // Result handed from the control logic to the output stage.
  typedef struct packed {
    logic [BLOCK_W-1:0] block;
    logic [SLOT_W-1:0]  slot;
    logic               from_free;
    pfla_status_e       status;
  } pfla_result_t;

endpackage

@@ sv/pfla_link_store.sv @@
// Link store of the free list: one write port, one registered read port.
module pfla_link_store #(
  parameter int DEPTH = pfla_pkg::MAX_BLOCKS_DEF * pfla_pkg::MAX_BLOCK_SLOTS,
  parameter int AW    = $clog2(DEPTH)
) (
  input  logic                clk_i,
  input  logic                wr_en_i,
  input  logic [AW-1:0]       wr_addr_i,
  input  pfla_pkg::pfla_link_t wr_data_i,
  input  logic [AW-1:0]       rd_addr_i,
  output pfla_pkg::pfla_link_t rd_data_o
);

  pfla_pkg::pfla_link_t mem [DEPTH];
  pfla_pkg::pfla_link_t rd_data_q;

  // Entries are only read after being written; no reset or clearing.
  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
    rd_data_q <= mem[rd_addr_i];
  end

  assign rd_data_o = rd_data_q;

endmodule

@@ sv/pfla_out_reg.sv @@
// Result stage: byte offset multiply and registered master-side output.
module pfla_out_reg (
  input  logic                               clk_i,
  input  logic                               rst_ni,
  input  logic                               res_valid_i,
  input  pfla_pkg::pfla_result_t             res_i,
  input  logic [pfla_pkg::BYTES_W-1:0]       elem_bytes_i,
  output logic                               res_ready_o,
  output logic                               m_tvalid_o,
  input  logic                               m_tready_i,
  output logic [31:0]                        m_tdata_o,
  output logic [1:0]                         m_tuser_o
);

  localparam int PROD_W = pfla_pkg::SLOT_W + pfla_pkg::BYTES_W;

  logic                               valid_q, valid_d;
  pfla_pkg::pfla_result_t             res_q;
  logic [pfla_pkg::OFF_W-1:0]         off_q, off_d;
  logic [PROD_W-1:0]                  prod;
  logic                               load;

  assign res_ready_o = !valid_q || m_tready_i;
  assign load        = res_valid_i && res_ready_o;

  assign prod  = PROD_W'(res_i.slot) * PROD_W'(elem_bytes_i);
  assign off_d = prod[pfla_pkg::OFF_W-1:0];

  always_comb begin
    valid_d = valid_q;
    if (load) begin
      valid_d = 1'b1;
    end else if (m_tready_i) begin
      valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= res_i;
      off_q <= off_d;
    end
  end

  assign m_tvalid_o = valid_q;
  assign m_tdata_o  = {4'b0, off_q, res_q.slot, res_q.block};
  assign m_tuser_o  = {res_q.status, res_q.from_free};

endmodule

@@ sv/pool_free_list_allocator_core.sv @@
// Top level of the fixed-size pool allocator with a LIFO free list.
// Each transfer on the slave side is an allocate (tuser 0) or a free (tuser 1) of
// the element in tdata (block * 64 + slot). Every request gives exactly one result
// transfer. An allocate pops the free-list head, else hands out the next fresh slot;
// when fresh slots of all MAX_BLOCKS blocks are used the result carries out-of-space
// status and nothing changes. A request is registered on acceptance and resolved
// once the result stage can take it; by then the link store's registered read of
// the next head is ready. A new request is taken while a result still waits on the
// master side. The link store needs no clearing pass after reset. Configuration is
// to be written only while the block is idle; the block does not enforce this.
module pool_free_list_allocator_core #(
  parameter int MAX_BLOCKS = pfla_pkg::MAX_BLOCKS_DEF
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  // configuration write port
  input  logic                          cfg_we_i,
  input  logic                          cfg_addr_i,
  input  logic [pfla_pkg::CFG_W-1:0]    cfg_wdata_i,
  // requests
  input  logic                          s_tvalid_i,
  output logic                          s_tready_o,
  input  logic [15:0]                   s_tdata_i,  // [9:0] element_index
  input  logic                          s_tuser_i,  // [0] opcode
  // results
  output logic                          m_tvalid_o,
  input  logic                          m_tready_i,
  output logic [31:0]                   m_tdata_o,  // [3:0] block_number, [9:4] slot,
                                                    // [27:10] byte_offset
  output logic [1:0]                    m_tuser_o   // [0] from_free_list, [1] status
);

  localparam int LINK_DEPTH = MAX_BLOCKS * pfla_pkg::MAX_BLOCK_SLOTS;
  localparam int AW         = $clog2(LINK_DEPTH);
  localparam int EW         = pfla_pkg::ELEM_W;
  localparam int SW         = pfla_pkg::SLOT_W;
  localparam int BW         = pfla_pkg::BLOCK_W;

  // configuration
  logic [pfla_pkg::EPB_W-1:0]   cfg_epb_q;
  logic [pfla_pkg::BYTES_W-1:0] cfg_bytes_q;
  logic [pfla_pkg::EPB_W-1:0]   eff_epb;
  logic [pfla_pkg::BYTES_W-1:0] eff_bytes;

  // request register
  logic                         busy_q, busy_d;
  pfla_pkg::pfla_op_e           in_op_q;
  logic [EW-1:0]                in_idx_q;
  logic                         accept, proc;

  // allocator state
  logic                         head_valid_q, head_valid_d;
  logic [EW-1:0]                head_q, head_d;
  logic                         fresh_started_q, fresh_started_d;
  logic [BW-1:0]                fresh_block_q, fresh_block_d;
  logic [SW-1:0]                fresh_slot_q, fresh_slot_d;

  logic [SW:0]                  next_slot;
  logic [BW:0]                  next_block;
  logic                         in_range;

  // link store and result stage
  logic                         wr_en;
  pfla_pkg::pfla_link_t         wr_link, rd_link;
  pfla_pkg::pfla_result_t       res;
  logic                         res_ready;

  // register clamps: zero counts as one, excess as the maximum
  always_comb begin
    eff_epb = cfg_epb_q;
    if (cfg_epb_q == '0) begin
      eff_epb = pfla_pkg::EPB_W'(1);
    end else if (32'(cfg_epb_q) > pfla_pkg::MAX_BLOCK_SLOTS) begin
      eff_epb = pfla_pkg::EPB_W'(pfla_pkg::MAX_BLOCK_SLOTS);
    end
    eff_bytes = cfg_bytes_q;
    if (cfg_bytes_q == '0) begin
      eff_bytes = pfla_pkg::BYTES_W'(1);
    end else if (32'(cfg_bytes_q) > pfla_pkg::MAX_ELEM_BYTES) begin
      eff_bytes = pfla_pkg::BYTES_W'(pfla_pkg::MAX_ELEM_BYTES);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_epb_q   <= pfla_pkg::EPB_W'(64);
      cfg_bytes_q <= pfla_pkg::BYTES_W'(8);
    end else if (cfg_we_i) begin
      case (pfla_pkg::pfla_cfg_e'(cfg_addr_i))
        pfla_pkg::CFG_ELEMENTS_PER_BLOCK: cfg_epb_q   <= cfg_wdata_i[pfla_pkg::EPB_W-1:0];
        pfla_pkg::CFG_ELEMENT_BYTES:      cfg_bytes_q <= cfg_wdata_i;
        default: ;
      endcase
    end
  end

  // one request in flight; it resolves once the result stage can take it
  assign s_tready_o = !busy_q;
  assign accept     = s_tvalid_i && !busy_q;
  assign proc       = busy_q && res_ready;

  always_comb begin
    busy_d = busy_q;
    if (accept) begin
      busy_d = 1'b1;
    end else if (proc) begin
      busy_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      in_op_q  <= pfla_pkg::pfla_op_e'(s_tuser_i);
      in_idx_q <= s_tdata_i[EW-1:0];
    end
  end

  assign next_slot  = {1'b0, fresh_slot_q} + (SW+1)'(1);
  assign next_block = {1'b0, fresh_block_q} + (BW+1)'(1);
  assign in_range   = 32'(in_idx_q) < LINK_DEPTH;
  assign wr_link    = '{valid: head_valid_q, idx: head_q};

  always_comb begin
    head_valid_d    = head_valid_q;
    head_d          = head_q;
    fresh_started_d = fresh_started_q;
    fresh_block_d   = fresh_block_q;
    fresh_slot_d    = fresh_slot_q;
    wr_en           = 1'b0;
    res             = '{block: '0, slot: '0, from_free: 1'b0, status: pfla_pkg::ST_DONE};
    if (proc) begin
      if (in_op_q == pfla_pkg::OP_FREE) begin
        // push: old head goes into the link of the freed element
        if (in_range) begin
          wr_en        = 1'b1;
          head_valid_d = 1'b1;
          head_d       = in_idx_q;
        end
      end else if (head_valid_q) begin
        // pop: link of the head was read on the cycle of acceptance
        head_valid_d  = rd_link.valid;
        head_d        = rd_link.idx;
        res.block     = head_q[EW-1:SW];
        res.slot      = head_q[SW-1:0];
        res.from_free = 1'b1;
      end else if (!fresh_started_q) begin
        fresh_started_d = 1'b1;
        fresh_block_d   = '0;
        fresh_slot_d    = '0;
      end else if (next_slot >= (SW+1)'(eff_epb)) begin
        if (32'(next_block) >= MAX_BLOCKS) begin
          res.status = pfla_pkg::ST_OUT_OF_SPACE;
        end else begin
          fresh_block_d = next_block[BW-1:0];
          fresh_slot_d  = '0;
          res.block     = next_block[BW-1:0];
        end
      end else begin
        fresh_slot_d = next_slot[SW-1:0];
        res.block    = fresh_block_q;
        res.slot     = next_slot[SW-1:0];
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q          <= 1'b0;
      head_valid_q    <= 1'b0;
      head_q          <= '0;
      fresh_started_q <= 1'b0;
      fresh_block_q   <= '0;
      fresh_slot_q    <= '0;
    end else begin
      busy_q          <= busy_d;
      head_valid_q    <= head_valid_d;
      head_q          <= head_d;
      fresh_started_q <= fresh_started_d;
      fresh_block_q   <= fresh_block_d;
      fresh_slot_q    <= fresh_slot_d;
    end
  end

  // read port follows the head, so the link of the head is registered for the next pop
  pfla_link_store #(
    .DEPTH (LINK_DEPTH),
    .AW    (AW)
  ) u_link_store (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (AW'(in_idx_q)),
    .wr_data_i (wr_link),
    .rd_addr_i (AW'(head_q)),
    .rd_data_o (rd_link)
  );

  pfla_out_reg u_out_reg (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .res_valid_i  (busy_q),
    .res_i        (res),
    .elem_bytes_i (eff_bytes),
    .res_ready_o  (res_ready),
    .m_tvalid_o   (m_tvalid_o),
    .m_tready_i   (m_tready_i),
    .m_tdata_o    (m_tdata_o),
    .m_tuser_o    (m_tuser_o)
  );

  // an accepted request is held until it resolves
  a_held: assert property (@(posedge clk_i) disable iff (!rst_ni)
    busy_q && !proc |=> busy_q)
    else $error("request dropped before resolving");

  // a resolved free of a valid element becomes the new head
  a_push: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc && in_op_q == pfla_pkg::OP_FREE && in_range
    |=> head_valid_q && head_q == $past(in_idx_q))
    else $error("freed element not at free-list head");

  // fresh allocation never passes the block bound
  a_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    32'(fresh_block_q) < MAX_BLOCKS)
    else $error("fresh block beyond pool");

  // no request is taken in the cycle its predecessor resolves
  a_gap: assert property (@(posedge clk_i) disable iff (!rst_ni)
    proc |-> !accept)
    else $error("request accepted while another resolves");

endmodule

@@ verif/testbench.sv @@
// Self-checking testbench for the pool free-list allocator core.
module testbench;
  timeunit 1ns;
  timeprecision 1ps;

  // The core is built with its default block count; the predictor follows it.
  localparam int N_BLOCKS    = pfla_pkg::MAX_BLOCKS_DEF;
  localparam int LINK_DEPTH  = N_BLOCKS * pfla_pkg::MAX_BLOCK_SLOTS;
  // Stretch without any transfer after which the watchdog ends the run; it lies
  // well above the long receiver hold.
  localparam int STALL_LIMIT = 1000;
  localparam int HOLD_CYCLES = 80;

  // One grant or acknowledge as seen on the result side.
  typedef struct packed {
    logic [pfla_pkg::BLOCK_W-1:0] blk;
    logic [pfla_pkg::SLOT_W-1:0]  slt;
    logic [pfla_pkg::OFF_W-1:0]   offset;
    logic                         recycled;
    pfla_pkg::pfla_status_e       status;
  } pool_grant_t;

  logic                       clk_i       = 1'b0;
  logic                       rst_ni      = 1'b0;
  logic                       cfg_we_i    = 1'b0;
  logic                       cfg_addr_i  = 1'b0;
  logic [pfla_pkg::CFG_W-1:0] cfg_wdata_i = '0;
  logic                       s_tvalid_i  = 1'b0;
  logic                       s_tready_o;
  logic [15:0]                s_tdata_i   = '0;   // [9:0] element_index
  logic                       s_tuser_i   = 1'b0; // [0] opcode
  logic                       m_tvalid_o;
  logic                       m_tready_i  = 1'b0;
  logic [31:0]                m_tdata_o;  // [3:0] block_number, [9:4] slot, [27:10] byte_offset
  logic [1:0]                 m_tuser_o;  // [0] from_free_list, [1] status

  pool_free_list_allocator_core u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .cfg_we_i    (cfg_we_i),
    .cfg_addr_i  (cfg_addr_i),
    .cfg_wdata_i (cfg_wdata_i),
    .s_tvalid_i  (s_tvalid_i),
    .s_tready_o  (s_tready_o),
    .s_tdata_i   (s_tdata_i),
    .s_tuser_i   (s_tuser_i),
    .m_tvalid_o  (m_tvalid_o),
    .m_tready_i  (m_tready_i),
    .m_tdata_o   (m_tdata_o),
    .m_tuser_o   (m_tuser_o)
  );

  always begin
    #10 clk_i = 1'b1;
    #10 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Pool mirror: free list, link store, fresh pointer and register copies
  // ---------------------------------------------------------------------------
  logic                        list_head_valid;
  logic [pfla_pkg::ELEM_W-1:0] list_head;
  logic                        link_valid [LINK_DEPTH];
  logic [pfla_pkg::ELEM_W-1:0] link_next  [LINK_DEPTH];
  bit                          pooled     [LINK_DEPTH]; // element currently on the free list
  bit                          fresh_begun;
  int unsigned                 fresh_blk, fresh_slt;
  int unsigned                 reg_epb   = 64;  // raw register values, clamped on use
  int unsigned                 reg_bytes = 8;

  pool_grant_t                 grants_due [$];     // expected results, oldest first
  logic [pfla_pkg::ELEM_W-1:0] live_elements [$];  // elements handed out, not yet returned

  // Run statistics and error tally
  int unsigned n_fresh, n_recycled, n_refused, n_frees, n_settings, n_checked;
  int unsigned n_errors;

  // Idle control for both sides
  bit          src_gaps  = 1'b1;
  bit          sink_gaps = 1'b1;
  int unsigned sink_hold = 0;  // long receiver hold, counted down by the sink
  int unsigned sink_wait = 0;

  initial begin
    list_head_valid = 1'b0;
    list_head       = '0;
    fresh_begun     = 1'b0;
    fresh_blk       = 0;
    fresh_slt       = 0;
    foreach (link_valid[i]) begin
      link_valid[i] = 1'b0;
      link_next[i]  = '0;
    end
  end

  // Works out the result of one request and moves the mirror on.
  function automatic pool_grant_t predict_pool(pfla_pkg::pfla_op_e op,
                                               logic [pfla_pkg::ELEM_W-1:0] idx);
    pool_grant_t                 g;
    int unsigned                 epb_eff, bytes_eff;
    logic [pfla_pkg::ELEM_W-1:0] e;
    g         = '0;
    epb_eff   = (reg_epb == 0) ? 1 :
                (reg_epb > pfla_pkg::MAX_BLOCK_SLOTS) ? pfla_pkg::MAX_BLOCK_SLOTS : reg_epb;
    bytes_eff = (reg_bytes == 0) ? 1 :
                (reg_bytes > pfla_pkg::MAX_ELEM_BYTES) ? pfla_pkg::MAX_ELEM_BYTES : reg_bytes;
    if (op == pfla_pkg::OP_FREE) begin
      // push onto the list; acknowledge is all zeros
      link_valid[idx] = list_head_valid;
      link_next[idx]  = list_head;
      list_head_valid = 1'b1;
      list_head       = idx;
      pooled[idx]     = 1'b1;
      n_frees++;
      return g;
    end
    if (list_head_valid) begin
      e               = list_head;
      list_head_valid = link_valid[e];
      list_head       = link_next[e];
      pooled[e]       = 1'b0;
      g.blk           = e[pfla_pkg::ELEM_W-1:pfla_pkg::SLOT_W];
      g.slt           = e[pfla_pkg::SLOT_W-1:0];
      g.recycled      = 1'b1;
      n_recycled++;
    end else begin
      if (!fresh_begun) begin
        fresh_begun = 1'b1;
        fresh_blk   = 0;
        fresh_slt   = 0;
      end else if (fresh_slt + 1 >= epb_eff) begin
        // block full (or shrunk under us): move on, or refuse if none left
        if (fresh_blk + 1 >= N_BLOCKS) begin
          g.status = pfla_pkg::ST_OUT_OF_SPACE;
          n_refused++;
          return g;
        end
        fresh_blk++;
        fresh_slt = 0;
      end else begin
        fresh_slt++;
      end
      g.blk = pfla_pkg::BLOCK_W'(fresh_blk);
      g.slt = pfla_pkg::SLOT_W'(fresh_slt);
      n_fresh++;
    end
    g.offset = pfla_pkg::OFF_W'(32'(g.slt) * bytes_eff);
    return g;
  endfunction

  // ---------------------------------------------------------------------------
  // Request side
  // ---------------------------------------------------------------------------
  // Offers one request, waits for its transfer and records what must come back.
  // Called in a step at a rising edge; leaves tvalid high so that a following
  // request without a gap keeps it high.
  task automatic send_request(input pfla_pkg::pfla_op_e op,
                              input logic [pfla_pkg::ELEM_W-1:0] idx);
    int          gap;
    int          hit[$];
    pool_grant_t g;
    gap = src_gaps ? $urandom_range(5, 0) : 0;
    if (gap > 0) begin
      s_tvalid_i <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    s_tvalid_i <= 1'b1;
    s_tdata_i  <= {6'b0, idx};
    s_tuser_i  <= op;
    do @(posedge clk_i); while (!s_tready_o);
    g = predict_pool(op, idx);
    grants_due.push_back(g);
    if (op == pfla_pkg::OP_FREE) begin
      hit = live_elements.find_first_index with (item == idx);
      if (hit.size() != 0) live_elements.delete(hit[0]);
    end else if (g.status == pfla_pkg::ST_DONE && !pooled[{g.blk, g.slt}]) begin
      // a fresh slot that a stray free already put on the list is not tracked
      // as live, so it is never freed twice
      live_elements.push_back({g.blk, g.slt});
    end
  endtask

  // Random element index within the pool.
  function automatic logic [pfla_pkg::ELEM_W-1:0] rand_elem();
    return pfla_pkg::ELEM_W'($urandom_range(LINK_DEPTH - 1, 0));
  endfunction

  // Mostly allocations and returns of live elements; a few stray frees of
  // elements that are not on the list (never a second free of a listed one).
  task automatic send_random_request();
    logic [pfla_pkg::ELEM_W-1:0] idx;
    int unsigned                 pick;
    idx  = rand_elem();
    pick = $urandom_range(99, 0);
    if (live_elements.size() == 0 || pick < (live_elements.size() < 48 ? 60 : 35)) begin
      send_request(pfla_pkg::OP_ALLOC, idx);
    end else if (pick >= 92) begin
      while (pooled[idx]) idx = rand_elem();
      send_request(pfla_pkg::OP_FREE, idx);
    end else begin
      send_request(pfla_pkg::OP_FREE,
                   live_elements[$urandom_range(live_elements.size() - 1, 0)]);
    end
  endtask

  // Sender stops and waits until every outstanding result has been taken.
  task automatic drain_results();
    s_tvalid_i <= 1'b0;
    do @(posedge clk_i); while (grants_due.size() != 0);
  endtask

  // Writes both registers back to back; only called with the core idle.
  task automatic set_config(input int unsigned epb, input int unsigned bytes);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= pfla_pkg::CFG_ELEMENTS_PER_BLOCK;
    cfg_wdata_i <= pfla_pkg::CFG_W'(epb);
    @(posedge clk_i);
    cfg_addr_i  <= pfla_pkg::CFG_ELEMENT_BYTES;
    cfg_wdata_i <= pfla_pkg::CFG_W'(bytes);
    @(posedge clk_i);
    cfg_we_i    <= 1'b0;
    reg_epb   = epb;
    reg_bytes = bytes;
    n_settings++;
  endtask

  // ---------------------------------------------------------------------------
  // Result side: checks each transfer and paces tready
  // ---------------------------------------------------------------------------
  always @(posedge clk_i) begin : result_sink
    pool_grant_t got, want;
    if (rst_ni) begin
      if (m_tvalid_o && m_tready_i) begin
        got.blk      = m_tdata_o[3:0];
        got.slt      = m_tdata_o[9:4];
        got.offset   = m_tdata_o[27:10];
        got.recycled = m_tuser_o[0];
        got.status   = pfla_pkg::pfla_status_e'(m_tuser_o[1]);
        n_checked++;
        if (grants_due.size() == 0) begin
          n_errors++;
          if (n_errors <= 10)
            $display("%0t: result transfer with nothing outstanding: blk %0d slot %0d",
                     $realtime, got.blk, got.slt);
        end else begin
          want = grants_due.pop_front();
          if (got.blk !== want.blk || got.slt !== want.slt || got.offset !== want.offset ||
              got.recycled !== want.recycled || got.status !== want.status) begin
            n_errors++;
            if (n_errors <= 10)
              $display("%0t: mismatch, expected blk %0d slot %0d off %0d rec %0d st %0d,",
                       $realtime, want.blk, want.slt, want.offset, want.recycled,
                       want.status,
                       " got blk %0d slot %0d off %0d rec %0d st %0d",
                       got.blk, got.slt, got.offset, got.recycled, got.status);
          end
        end
        sink_wait = sink_gaps ? $urandom_range(5, 0) : 0;
      end
      // long hold first, then the per-result gap, otherwise ready
      if (sink_hold > 0) begin
        sink_hold--;
        m_tready_i <= 1'b0;
      end else if (sink_wait > 0) begin
        sink_wait--;
        m_tready_i <= 1'b0;
      end else begin
        m_tready_i <= 1'b1;
      end
    end
  end

  // Ends the run if neither side sees a transfer for too long.
  initial begin : watchdog
    int unsigned quiet;
    quiet = 0;
    while (quiet < STALL_LIMIT) begin
      @(posedge clk_i);
      if (!rst_ni || (s_tvalid_i && s_tready_o) || (m_tvalid_o && m_tready_i)) quiet = 0;
      else quiet++;
    end
    $display("watchdog: no transfer for %0d cycles, %0d results outstanding",
             STALL_LIMIT, grants_due.size());
    $display("FAILURE");
    $finish;
  end

  // ---------------------------------------------------------------------------
  // Tests
  // ---------------------------------------------------------------------------
  // Hand-picked sequence: fresh and recycled grants, index extremes, register
  // clamping at both ends, a fresh slot left beyond a shrunk block, and a
  // recycled slot beyond the current block size.
  task automatic test_directed();
    // reset settings: 64 per block, 8 bytes
    send_request(pfla_pkg::OP_ALLOC, '0);      // fresh 0/0
    send_request(pfla_pkg::OP_ALLOC, '1);      // index ignored on alloc: fresh 0/1
    send_request(pfla_pkg::OP_FREE,  '1);      // element 15/63, never handed out
    send_request(pfla_pkg::OP_FREE,  '0);
    send_request(pfla_pkg::OP_ALLOC, 10'd5);   // recycles 0/0 (last in, first out)
    send_request(pfla_pkg::OP_ALLOC, 10'd5);   // recycles 15/63
    send_request(pfla_pkg::OP_ALLOC, 10'd5);   // list empty again: fresh 0/2
    drain_results();
    // both registers above their limits: clamp to 64 slots and 4096 bytes
    set_config(127, 8191);
    send_request(pfla_pkg::OP_FREE,  10'd63);
    send_request(pfla_pkg::OP_ALLOC, 10'd0);   // largest offset, 63 * 4096
    send_request(pfla_pkg::OP_ALLOC, 10'd0);   // fresh 0/3
    drain_results();
    // zero in both: treated as one slot per block and one byte
    set_config(0, 0);
    send_request(pfla_pkg::OP_ALLOC, 10'd0);   // slot 3 lies past the block end: fresh 1/0
    send_request(pfla_pkg::OP_FREE,  10'd1000);
    send_request(pfla_pkg::OP_ALLOC, 10'd0);   // recycles 15/40, slot beyond block size
    send_request(pfla_pkg::OP_ALLOC, 10'd0);   // fresh 2/0
    drain_results();
    set_config(64, 4096);
    send_request(pfla_pkg::OP_ALLOC, 10'd0);   // fresh 2/1
    drain_results();
  endtask

  // Several phases of random traffic, each with its own settings and idling.
  task automatic test_random_mix();
    int unsigned epb, bytes;
    for (int ph = 0; ph < 5; ph++) begin
      epb   = (ph == 2) ? 127 : $urandom_range(64, 16);
      bytes = (ph == 1) ? 4096 : (ph == 3) ? 1 : $urandom_range(4096, 1);
      set_config(epb, bytes);
      src_gaps  = (ph % 2 == 0);
      sink_gaps = (ph % 3 != 1);
      repeat (170) send_random_request();
      drain_results();
    end
  endtask

  // Receiver holds off long enough that the core fills and stalls its input,
  // then the sender waits for every result before going on.
  task automatic test_backpressure();
    src_gaps  = 1'b0;
    sink_gaps = 1'b0;
    sink_hold = HOLD_CYCLES;
    repeat (24) send_random_request();
    drain_results();
    src_gaps  = 1'b1;
    sink_gaps = 1'b1;
    repeat (24) send_random_request();
    drain_results();
  endtask

  // Small blocks so the fresh pointer runs out; refusals must change nothing.
  task automatic test_exhaustion();
    int unsigned refused_before;
    set_config(2, 100);
    refused_before = n_refused;
    for (int g = 0; g < 1500 && n_refused == refused_before; g++)
      send_request(pfla_pkg::OP_ALLOC, rand_elem());
    repeat (3) send_request(pfla_pkg::OP_ALLOC, rand_elem());
    // returned elements are still served while fresh space is gone
    repeat (3) send_request(pfla_pkg::OP_FREE, live_elements[live_elements.size() - 1]);
    repeat (4) send_request(pfla_pkg::OP_ALLOC, rand_elem());
    drain_results();
  endtask

  // Larger blocks after exhaustion: the last block has room again.
  task automatic test_recovery();
    set_config(64, 4096);
    repeat (150) send_random_request();
    drain_results();
  endtask

  // Double free is not caught: the element links to itself and keeps coming back.
  task automatic test_double_free();
    logic [pfla_pkg::ELEM_W-1:0] idx;
    idx = rand_elem();
    while (pooled[idx]) idx = rand_elem();
    send_request(pfla_pkg::OP_FREE, idx);
    send_request(pfla_pkg::OP_FREE, idx);
    repeat (3) send_request(pfla_pkg::OP_ALLOC, rand_elem());
    drain_results();
  endtask

  initial begin : run
    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    test_directed();
    test_random_mix();
    test_backpressure();
    test_exhaustion();
    test_recovery();
    test_double_free();

    drain_results();
    repeat (8) @(posedge clk_i);  // let any stray result show up
    if (grants_due.size() != 0) n_errors++;

    $display("covered %0d fresh, %0d recycled and %0d refused allocations, %0d frees",
             n_fresh, n_recycled, n_refused, n_frees);
    $display("%0d register settings, %0d results checked, %0d errors",
             n_settings, n_checked, n_errors);
    if (n_errors == 0) begin
      $display("SUCCESS");
    end else begin
      $display("FAILURE");
    end
    $finish;
  end

endmodule
